/* rtl/va_sa_pkg.sv */
// Shared types and codes for the slot allocator with fault decode.
// Holds the request and response beat layouts, opcodes and status codes.
// Depends on nothing; the top level imports it.
package va_sa_pkg;

	localparam int SLOT_COUNT_DEF  = 32;
	localparam int STRIDE_LOG2_DEF = 31;

	localparam int IDX_W = 6;

	localparam logic [2:0] OP_ALLOC     = 3'd0;
	localparam logic [2:0] OP_RELEASE   = 3'd1;
	localparam logic [2:0] OP_SET_OWNER = 3'd2;
	localparam logic [2:0] OP_FAULT     = 3'd3;
	localparam logic [2:0] OP_CONTAINS  = 3'd4;
	localparam logic [2:0] OP_SLOT_ADDR = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_OUTSIDE = 2'd2;
	localparam logic [1:0] ST_RANGE   = 2'd3;

	typedef struct packed {
		logic [2:0]       opcode;
		logic [IDX_W-1:0] slot_index;
		logic [31:0]      owner_tag;
		logic [63:0]      query_address;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] granted_or_found_slot;
		logic [31:0]      slot_owner;
		logic [30:0]      offset_in_slot;
		logic             slot_reserved;
		logic [63:0]      slot_base_address;
	} rsp_t;

endpackage

/* rtl/va_slot_allocator_with_fault_decode_core.sv */
// Top level of the slot allocator over a virtual-address window, with fault decode.
// Holds the occupancy flops, the owner-tag memory and the two-stage request path.
// Depends on va_sa_pkg for beat layouts, opcodes and status codes.
//
//  Channel | Signals                        | Direction | Beat
//  --------+--------------------------------+-----------+------------------------------
//  request | req_valid, req_stall, req      | in        | req_t: opcode, slot, tag, addr
//  result  | rsp_valid, rsp_stall, rsp      | out       | rsp_t: status, slot, owner ...
//  config  | cfg_we, cfg_data               | in        | 64-bit window base address
//
// A request beat is accepted into stage 1, moves on to stage 2 and then lands in
// the output register. The owner-tag memory has a registered read port, and
// stage 1 reads and writes the shared state, so the block holds one request at
// a time: a new beat is not taken while stage 1 is busy or stage 2 is held.
// The output register separates the sides: a request is accepted while the
// previous result still waits, and stage 2 holds while the output is stalled.
// Reset clears the occupancy bits, the per-entry owner valid bits and the base
// register at once; there is no clearing pass over the owner memory.
module va_slot_allocator_with_fault_decode_core
	import va_sa_pkg::*;
#(
	parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
	parameter int STRIDE_LOG2 = STRIDE_LOG2_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp
);

	// Address width of the slot-indexed storage.
	localparam int AW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	// Width of the address bits above the slot stride.
	localparam int HIW = 64 - STRIDE_LOG2;
	// Offset bits that survive into the 31-bit offset field.
	localparam logic [30:0] OFF_MASK = (STRIDE_LOG2 >= 31) ? 31'h7FFF_FFFF
		: 31'((64'd1 << STRIDE_LOG2) - 64'd1);

	// Configuration and allocator state.
	logic [63:0]           base_q;
	logic [SLOT_COUNT-1:0] occ_q;
	logic [SLOT_COUNT-1:0] tag_vld_q;
	logic [31:0]           tag_mem [SLOT_COUNT];
	logic [31:0]           rd_data_q;
	logic                  rd_vld_q;

	// Pipeline.
	logic        v_s1;
	req_t        req_s1;
	logic        v_s2;
	logic        own_en_s2;
	rsp_t        rsp_s2;
	rsp_t        rsp_fin;
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic        req_acc;
	logic        s2_adv;

	// Stage 1 decode.
	logic [64:0]    diff;
	logic [63:0]    rel;
	logic           in_window;
	logic           idx_ok;
	logic           free_found;
	logic [AW-1:0]  free_idx;
	logic [AW-1:0]  idx_a;
	logic [AW-1:0]  fault_a;
	logic           tag_we;
	logic [31:0]    tag_wdata;
	logic           tag_re;
	logic           occ_set;
	logic           occ_clr;
	rsp_t           rsp_d;

	// Handshake. Stage 2 may hand over to the output register in the same
	// cycle that a new beat enters stage 1.
	assign s2_adv    = !rsp_valid_q || !rsp_stall;
	assign req_stall = v_s1 || (v_s2 && !s2_adv);
	assign req_acc   = req_valid && !req_stall;

	// Window test without wraparound: the subtraction must not borrow, and the
	// bits of the offset above one stride must name a slot below SLOT_COUNT.
	assign diff      = {1'b0, req_s1.query_address} - {1'b0, base_q};
	assign rel       = diff[63:0];
	assign in_window = !diff[64] && (rel[63:STRIDE_LOG2] < HIW'(SLOT_COUNT));

	assign idx_ok  = {1'b0, req_s1.slot_index} < (IDX_W + 1)'(SLOT_COUNT);
	assign idx_a   = req_s1.slot_index[AW-1:0];
	assign fault_a = rel[STRIDE_LOG2 +: AW];

	// Lowest free slot: scan from the top so the lowest index wins.
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!occ_q[i]) begin
				free_found = 1'b1;
				free_idx   = AW'(i);
			end
		end
	end

	// Stage 1: form everything except the owner tag, which comes from memory.
	always_comb begin
		rsp_d     = '0;
		tag_we    = 1'b0;
		tag_wdata = req_s1.owner_tag;
		tag_re    = 1'b0;
		occ_set   = 1'b0;
		occ_clr   = 1'b0;
		case (req_s1.opcode)
			OP_ALLOC: begin
				if (free_found) begin
					occ_set                     = v_s1;
					rsp_d.granted_or_found_slot = IDX_W'(free_idx);
				end else begin
					rsp_d.status = ST_FULL;
				end
			end
			OP_RELEASE: begin
				if (idx_ok) begin
					occ_clr = v_s1;
				end else begin
					rsp_d.status = ST_RANGE;
				end
			end
			OP_SET_OWNER: begin
				if (idx_ok) begin
					tag_we = v_s1;
				end else begin
					rsp_d.status = ST_RANGE;
				end
			end
			OP_FAULT: begin
				if (in_window) begin
					tag_re                      = v_s1;
					rsp_d.granted_or_found_slot = rel[STRIDE_LOG2 +: IDX_W];
					rsp_d.offset_in_slot        = rel[30:0] & OFF_MASK;
					rsp_d.slot_reserved         = occ_q[fault_a];
				end else begin
					rsp_d.status = ST_OUTSIDE;
				end
			end
			OP_CONTAINS: begin
				if (!in_window) begin
					rsp_d.status = ST_OUTSIDE;
				end
			end
			OP_SLOT_ADDR: begin
				// No range check here: any index is scaled and added, modulo 2^64.
				rsp_d.slot_base_address = base_q + (64'(req_s1.slot_index) << STRIDE_LOG2);
			end
			default: begin
			end
		endcase
	end

	// Control registers: pipeline valids, output valid, base, occupancy and
	// the per-entry valid bits that make an unwritten owner tag read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			rsp_valid_q <= 1'b0;
			base_q      <= '0;
			occ_q       <= '0;
			tag_vld_q   <= '0;
			rd_vld_q    <= 1'b0;
		end else begin
			v_s1        <= req_acc;
			v_s2        <= v_s1 || (v_s2 && !s2_adv);
			rsp_valid_q <= (v_s2 && s2_adv) || (rsp_valid_q && rsp_stall);
			if (cfg_we) begin
				base_q <= cfg_data;
			end
			if (occ_set) begin
				occ_q[free_idx] <= 1'b1;
			end
			if (occ_clr) begin
				occ_q[idx_a]     <= 1'b0;
				tag_vld_q[idx_a] <= 1'b0;
			end
			if (tag_we) begin
				tag_vld_q[idx_a] <= 1'b1;
			end
			if (tag_re) begin
				rd_vld_q <= tag_vld_q[fault_a];
			end
		end
	end

	// Owner-tag memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[idx_a] <= tag_wdata;
		end
		if (tag_re) begin
			rd_data_q <= tag_mem[fault_a];
		end
	end

	// Stage 2 output: the owner tag from memory joins the rest of the beat here.
	always_comb begin
		rsp_fin            = rsp_s2;
		rsp_fin.slot_owner = (own_en_s2 && rd_vld_q) ? rd_data_q : 32'd0;
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_s1 <= req;
		end
		if (v_s1) begin
			rsp_s2    <= rsp_d;
			own_en_s2 <= tag_re;
		end
		if (v_s2 && s2_adv) begin
			rsp_q <= rsp_fin;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Only one request is ever inside the two stages.
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1 && v_s2))
		else $error("two requests in flight");

	// A granted slot is marked allocated right after the grant.
	a_alloc_sets: assert property (@(posedge clk) disable iff (!arst_n)
		occ_set |=> occ_q[$past(free_idx)])
		else $error("allocated slot not marked busy");

	// A release leaves its slot free and its owner tag reading as zero.
	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		occ_clr |=> (!occ_q[$past(idx_a)] && !tag_vld_q[$past(idx_a)]))
		else $error("released slot still busy or tagged");

	// A full pool answers with slot zero and a zero owner tag.
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_FULL) |->
		(rsp.granted_or_found_slot == '0 && rsp.slot_owner == 32'd0))
		else $error("full status carries a slot");

endmodule
